[rtl/pdp11pd_pkg.sv]
// Shared types, constants and the opcode/mask table of the PDP-11 instruction predecoder.
// No dependencies; every module of the block imports this package.
package pdp11pd_pkg;

   localparam int NUM_ENTRIES = 63;
   localparam int ENTRY_W     = 6;
   localparam int WORD_W      = 16;

   typedef enum logic [2:0] {
      CL_NONE   = 3'd0,
      CL_DOUBLE = 3'd1,
      CL_SINGLE = 3'd2,
      CL_JSR    = 3'd3,
      CL_BRANCH = 3'd4,
      CL_JMP    = 3'd5,
      CL_SOB    = 3'd6
   } op_class_type;

   // Per-stage handshake control handed from the top level to each stage.
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

   localparam logic [WORD_W-1:0] OP_TABLE [NUM_ENTRIES] = '{
      16'o010000, 16'o110000, 16'o020000, 16'o120000,
      16'o030000, 16'o130000, 16'o040000, 16'o140000,
      16'o050000, 16'o150000, 16'o060000, 16'o160000,
      16'o070000, 16'o071000, 16'o072000, 16'o073000,
      16'o074000, 16'o077000, 16'o000300, 16'o004000,
      16'o005000, 16'o005100, 16'o005200, 16'o005300,
      16'o005400, 16'o005500, 16'o005600, 16'o005700,
      16'o006000, 16'o006100, 16'o006200, 16'o006300,
      16'o006400, 16'o106400, 16'o006500, 16'o106500,
      16'o006600, 16'o106600, 16'o006700, 16'o106700,
      16'o000400, 16'o001000, 16'o001400, 16'o002000,
      16'o002400, 16'o003000, 16'o003400, 16'o100000,
      16'o100400, 16'o102000, 16'o102400, 16'o103000,
      16'o103400, 16'o000100, 16'o000207,
      16'o000000, 16'o000001, 16'o000002, 16'o000003,
      16'o000004, 16'o000005, 16'o000006,
      16'o000000
   };

   localparam logic [WORD_W-1:0] MASK_TABLE [NUM_ENTRIES] = '{
      16'o170000, 16'o170000, 16'o170000, 16'o170000,
      16'o170000, 16'o170000, 16'o170000, 16'o170000,
      16'o170000, 16'o170000, 16'o170000, 16'o170000,
      16'o177000, 16'o177000, 16'o177000, 16'o177000,
      16'o177000, 16'o177000, 16'o077700, 16'o177000,
      16'o077700, 16'o077700, 16'o077700, 16'o077700,
      16'o077700, 16'o077700, 16'o077700, 16'o077700,
      16'o077700, 16'o077700, 16'o077700, 16'o077700,
      16'o077700, 16'o077700, 16'o077700, 16'o077700,
      16'o077700, 16'o077700, 16'o077700, 16'o077700,
      16'o007400, 16'o007400, 16'o007400, 16'o007400,
      16'o007400, 16'o007400, 16'o007400, 16'o177400,
      16'o177400, 16'o177400, 16'o177400, 16'o177400,
      16'o177400, 16'o177700, 16'o077777,
      16'o077777, 16'o077777, 16'o077777, 16'o077777,
      16'o077777, 16'o077777, 16'o077777,
      16'o000000
   };

   localparam op_class_type CLASS_TABLE [NUM_ENTRIES] = '{
      CL_DOUBLE, CL_DOUBLE, CL_DOUBLE, CL_DOUBLE,
      CL_DOUBLE, CL_DOUBLE, CL_DOUBLE, CL_DOUBLE,
      CL_DOUBLE, CL_DOUBLE, CL_DOUBLE, CL_DOUBLE,
      CL_DOUBLE, CL_DOUBLE, CL_DOUBLE, CL_DOUBLE,
      CL_DOUBLE, CL_SOB,    CL_SINGLE, CL_JSR,
      CL_SINGLE, CL_SINGLE, CL_SINGLE, CL_SINGLE,
      CL_SINGLE, CL_SINGLE, CL_SINGLE, CL_SINGLE,
      CL_SINGLE, CL_SINGLE, CL_SINGLE, CL_SINGLE,
      CL_SINGLE, CL_SINGLE, CL_SINGLE, CL_SINGLE,
      CL_SINGLE, CL_SINGLE, CL_SINGLE, CL_SINGLE,
      CL_BRANCH, CL_BRANCH, CL_BRANCH, CL_BRANCH,
      CL_BRANCH, CL_BRANCH, CL_BRANCH, CL_BRANCH,
      CL_BRANCH, CL_BRANCH, CL_BRANCH, CL_BRANCH,
      CL_BRANCH, CL_JMP,    CL_NONE,
      CL_NONE,   CL_NONE,   CL_NONE,   CL_NONE,
      CL_NONE,   CL_NONE,   CL_NONE,
      CL_NONE
   };

   // One extension word for index modes, and for immediate or absolute through the PC.
   function automatic logic operand_extra(input logic [5:0] spec);
      logic [2:0] mode;
      logic [2:0] rnum;
      mode = spec[5:3];
      rnum = spec[2:0];
      return (mode == 3'd6) || (mode == 3'd7) ||
             ((rnum == 3'd7) && ((mode == 3'd2) || (mode == 3'd3)));
   endfunction

endpackage

[rtl/pdp11pd_match.sv]
// First stage: registers the word and address and the match vector against every table entry.
// Depends on pdp11pd_pkg.
module pdp11pd_match (
   input  logic                               clock,
   input  logic                               reset,
   input  pdp11pd_pkg::pipe_ctl_type          ctl,
   input  logic [pdp11pd_pkg::WORD_W-1:0]     word,
   input  logic [pdp11pd_pkg::WORD_W-1:0]     addr,
   output logic                               valid,
   output logic [pdp11pd_pkg::NUM_ENTRIES-1:0] hit,
   output logic [pdp11pd_pkg::WORD_W-1:0]     word_out,
   output logic [pdp11pd_pkg::WORD_W-1:0]     addr_out
);
   import pdp11pd_pkg::*;

   logic                    valid_ff;
   logic [NUM_ENTRIES-1:0]  hit_ff, hit_in;
   logic [WORD_W-1:0]       word_ff, addr_ff;

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         hit_in[i] = ((word & MASK_TABLE[i]) == OP_TABLE[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         hit_ff  <= hit_in;
         word_ff <= word;
         addr_ff <= addr;
      end
   end

   assign valid    = valid_ff;
   assign hit      = hit_ff;
   assign word_out = word_ff;
   assign addr_out = addr_ff;

endmodule

[rtl/pdp11pd_encode.sv]
// Second stage: priority-encodes the match vector and precomputes extension-word flags and targets.
// Depends on pdp11pd_pkg.
module pdp11pd_encode (
   input  logic                                clock,
   input  logic                                reset,
   input  pdp11pd_pkg::pipe_ctl_type           ctl,
   input  logic [pdp11pd_pkg::NUM_ENTRIES-1:0] hit,
   input  logic [pdp11pd_pkg::WORD_W-1:0]      word,
   input  logic [pdp11pd_pkg::WORD_W-1:0]      addr,
   output logic                                valid,
   output logic [pdp11pd_pkg::ENTRY_W-1:0]     index,
   output logic                                src_extra,
   output logic                                dst_extra,
   output logic [2:0]                          reg_num,
   output logic [pdp11pd_pkg::WORD_W-1:0]      br_target,
   output logic [pdp11pd_pkg::WORD_W-1:0]      sob_target
);
   import pdp11pd_pkg::*;

   logic               valid_ff;
   logic [ENTRY_W-1:0] index_ff, index_in;
   logic               src_extra_ff, dst_extra_ff;
   logic [2:0]         reg_num_ff;
   logic [WORD_W-1:0]  br_target_ff, br_target_in;
   logic [WORD_W-1:0]  sob_target_ff, sob_target_in;

   // The last entry has an empty mask, so it is the default when nothing earlier hits.
   always_comb begin
      index_in = ENTRY_W'(NUM_ENTRIES - 1);
      for (int i = NUM_ENTRIES - 2; i >= 0; i--) begin
         if (hit[i]) begin
            index_in = ENTRY_W'(i);
         end
      end
   end

   assign br_target_in  = addr + WORD_W'(2) + {{(WORD_W-9){word[7]}}, word[7:0], 1'b0};
   assign sob_target_in = addr + WORD_W'(2) - {{(WORD_W-7){1'b0}}, word[5:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         index_ff      <= index_in;
         src_extra_ff  <= operand_extra(word[11:6]);
         dst_extra_ff  <= operand_extra(word[5:0]);
         reg_num_ff    <= word[8:6];
         br_target_ff  <= br_target_in;
         sob_target_ff <= sob_target_in;
      end
   end

   assign valid      = valid_ff;
   assign index      = index_ff;
   assign src_extra  = src_extra_ff;
   assign dst_extra  = dst_extra_ff;
   assign reg_num    = reg_num_ff;
   assign br_target  = br_target_ff;
   assign sob_target = sob_target_ff;

endmodule

[rtl/pdp11pd_finish.sv]
// Third stage and output register: looks up the class, forms the length and selects the target.
// Depends on pdp11pd_pkg.
module pdp11pd_finish (
   input  logic                            clock,
   input  logic                            reset,
   input  pdp11pd_pkg::pipe_ctl_type       ctl,
   input  logic [pdp11pd_pkg::ENTRY_W-1:0] index,
   input  logic                            src_extra,
   input  logic                            dst_extra,
   input  logic [2:0]                      reg_num,
   input  logic [pdp11pd_pkg::WORD_W-1:0]  br_target,
   input  logic [pdp11pd_pkg::WORD_W-1:0]  sob_target,
   output logic                            valid,
   output logic [pdp11pd_pkg::ENTRY_W-1:0] index_out,
   output logic [2:0]                      op_class,
   output logic [1:0]                      length_words,
   output logic [2:0]                      reg_field,
   output logic [pdp11pd_pkg::WORD_W-1:0]  target_addr,
   output logic                            target_valid
);
   import pdp11pd_pkg::*;

   op_class_type       cls;
   logic               valid_ff;
   logic [ENTRY_W-1:0] index_ff;
   logic [2:0]         class_ff;
   logic [1:0]         length_ff, length_in;
   logic [2:0]         reg_ff;
   logic [WORD_W-1:0]  target_ff, target_in;
   logic               tvalid_ff, tvalid_in;

   assign cls = CLASS_TABLE[index];

   always_comb begin
      length_in = 2'd1;
      target_in = '0;
      tvalid_in = 1'b0;
      case (cls)
         CL_DOUBLE: begin
            length_in = 2'd1 + {1'b0, src_extra} + {1'b0, dst_extra};
         end
         CL_SINGLE, CL_JSR, CL_JMP: begin
            length_in = 2'd1 + {1'b0, dst_extra};
         end
         CL_BRANCH: begin
            target_in = br_target;
            tvalid_in = 1'b1;
         end
         CL_SOB: begin
            target_in = sob_target;
            tvalid_in = 1'b1;
         end
         default: begin
            length_in = 2'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         index_ff  <= index;
         class_ff  <= cls;
         length_ff <= length_in;
         reg_ff    <= reg_num;
         target_ff <= target_in;
         tvalid_ff <= tvalid_in;
      end
   end

   assign valid        = valid_ff;
   assign index_out    = index_ff;
   assign op_class     = class_ff;
   assign length_words = length_ff;
   assign reg_field    = reg_ff;
   assign target_addr  = target_ff;
   assign target_valid = tvalid_ff;

endmodule

[rtl/pdp11_instruction_predecode_top.sv]
// PDP-11 instruction predecoder, three register stages: match, encode, finish.
// A new word can be taken every cycle while req_stall is low, and it is registered
// by match, encode and finish in turn. Each stage holds its word while the
// stage after it is full and stalled and fills whenever it is empty, so bubbles
// close up and req_stall rises only when all three stages hold words and rsp_stall
// is high. The depth is set by the 63-entry table match, its priority encoder and
// the class lookup with the target select, one per stage.
// Depends on pdp11pd_pkg, pdp11pd_match, pdp11pd_encode and pdp11pd_finish.
module pdp11_instruction_predecode_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_instr_word,
   input  logic [15:0] req_instr_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_entry_index,
   output logic [2:0]  rsp_op_class,
   output logic [1:0]  rsp_length_words,
   output logic [2:0]  rsp_reg_field,
   output logic [15:0] rsp_target_addr,
   output logic        rsp_target_valid
);
   import pdp11pd_pkg::*;

   pipe_ctl_type           ctl1, ctl2, ctl3;
   logic                   v1, v2, v3;
   logic                   adv1, adv2, adv3;
   logic [NUM_ENTRIES-1:0] hit1;
   logic [WORD_W-1:0]      word1, addr1;
   logic [ENTRY_W-1:0]     index2;
   logic                   src_extra2, dst_extra2;
   logic [2:0]             reg2;
   logic [WORD_W-1:0]      br_target2, sob_target2;

   // A stage may load when it is empty or when its contents move on this cycle.
   assign adv3 = !v3 || !rsp_stall;
   assign adv2 = !v2 || adv3;
   assign adv1 = !v1 || adv2;

   assign ctl1 = '{advance: adv1, valid: req_valid};
   assign ctl2 = '{advance: adv2, valid: v1};
   assign ctl3 = '{advance: adv3, valid: v2};

   assign req_stall = !adv1;
   assign rsp_valid = v3;

   pdp11pd_match u_match (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl1),
      .word     (req_instr_word),
      .addr     (req_instr_addr),
      .valid    (v1),
      .hit      (hit1),
      .word_out (word1),
      .addr_out (addr1)
   );

   pdp11pd_encode u_encode (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl2),
      .hit        (hit1),
      .word       (word1),
      .addr       (addr1),
      .valid      (v2),
      .index      (index2),
      .src_extra  (src_extra2),
      .dst_extra  (dst_extra2),
      .reg_num    (reg2),
      .br_target  (br_target2),
      .sob_target (sob_target2)
   );

   pdp11pd_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl3),
      .index        (index2),
      .src_extra    (src_extra2),
      .dst_extra    (dst_extra2),
      .reg_num      (reg2),
      .br_target    (br_target2),
      .sob_target   (sob_target2),
      .valid        (v3),
      .index_out    (rsp_entry_index),
      .op_class     (rsp_op_class),
      .length_words (rsp_length_words),
      .reg_field    (rsp_reg_field),
      .target_addr  (rsp_target_addr),
      .target_valid (rsp_target_valid)
   );

   // An open output must never hold back the input side.
   a_no_stall_when_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is open");

   a_target_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_target_valid ==
         ((rsp_op_class == CL_BRANCH) || (rsp_op_class == CL_SOB))))
      else $error("target flag disagrees with class");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_length_words != 2'd0) &&
         ((rsp_length_words == 2'd1) || (rsp_op_class == CL_DOUBLE) ||
          (rsp_op_class == CL_SINGLE) || (rsp_op_class == CL_JSR) ||
          (rsp_op_class == CL_JMP))))
      else $error("length out of range for class");

   // A word accepted into an empty pipe, with the output unstalled throughout, reaches the output.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !v1 && !v2 && !v3 && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("accepted word did not reach the output");

endmodule
